// ===== hw/rtl/mersenne_twister_generator_top_macros.svh =====
// Assertion macros for the MT19937 generator.
// Included by mersenne_twister_generator_top; expects clk and arst_n in scope.
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define MTG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtg assertion failed");
// Next-cycle implication, checked out of reset
`define MTG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtg assertion failed");
`else
`define MTG_ASSERT_NOW(lbl, ante, cons)
`define MTG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/mtg_pkg.sv =====
// Constants, types and helper functions for the MT19937 generator.
// No dependencies; imported by mersenne_twister_generator_top.
`timescale 1ns / 1ps
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int SHIFT_OFFSET = 397;
	localparam int IDX_W        = 10;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [31:0]      word_t;

	localparam idx_t LAST_IDX   = idx_t'(STATE_WORDS - 1);
	localparam idx_t WORDS_IDX  = idx_t'(STATE_WORDS);
	localparam idx_t WRAP_START = idx_t'(STATE_WORDS - SHIFT_OFFSET);
	localparam idx_t FAR_ADD    = idx_t'(SHIFT_OFFSET);

	localparam word_t INIT_MULT    = 32'd1812433253;
	localparam word_t TWIST_MATRIX = 32'h9908_B0DF;
	localparam word_t UPPER_BIT    = 32'h8000_0000;
	localparam word_t LOWER_BITS   = 32'h7FFF_FFFF;
	localparam word_t TEMPER_B     = 32'h9D2C_5680;
	localparam word_t TEMPER_C     = 32'hEFC6_0000;
	localparam word_t SEED_RESET   = 32'd5489;

	// Register map: word index of each APB register
	localparam logic REG_SEED = 1'b0;

	// One twist step: far ^ mix(hi, lo)
	function automatic word_t twist_word(word_t hi, word_t lo, word_t far);
		word_t y;
		y = (hi & UPPER_BIT) | (lo & LOWER_BITS);
		return far ^ (y >> 1) ^ (lo[0] ? TWIST_MATRIX : 32'd0);
	endfunction

	// Output tempering
	function automatic word_t temper(word_t x);
		word_t t;
		t = x ^ (x >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

endpackage

// ===== hw/rtl/mersenne_twister_generator_top.sv =====
// MT19937 generator top level: state memory, seed/twist sequencer, output register.
// Depends on mtg_pkg and mersenne_twister_generator_top_macros.svh.
`timescale 1ns / 1ps
`include "mersenne_twister_generator_top_macros.svh"

// MT19937 32-bit generator. Each draw transfer returns one tempered word; read as
// unsigned 0.32 fixed point it is a fraction in [0,1). The 624-word state sits in
// one memory with two registered read ports and one write port. A plain draw holds
// the input side through accept, read issue and read data; read data waits until
// the output register is free, then loads the word. The first draw after reset,
// and any draw with reseed set, first runs the seed recurrence, one word per cycle
// through the 32x32 multiplier. Every 624th draw (and the first after seeding)
// regenerates the whole state in place, one word per cycle through the memory
// read/write path. The next draw is taken once the current one has reached the
// output register; a result waiting there does not hold off the next transfer.
module mersenne_twister_generator_top (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// draw request channel
	input  logic               draw_valid,
	output logic               draw_ready,
	input  logic               reseed,
	// result channel
	output logic               word_valid,
	input  logic               word_ready,
	output mtg_pkg::word_t     random_word
);
	import mtg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_TW_PRIME,
		ST_TW_RUN,
		ST_TW_END,
		ST_RD_ISSUE,
		ST_RD_DATA
	} mtg_state_t;

	mtg_state_t state_q;
	word_t      seed_q;
	idx_t       read_idx_q;
	logic       seeded_q;
	idx_t       k_q;
	word_t      prev_q;
	word_t      cur_q;
	logic       tw_v_s1;
	idx_t       tw_k_s1;
	word_t      random_word_q;
	logic       word_valid_q;

	// state memory and its ports
	word_t mem [STATE_WORDS];
	word_t rd_a_q;
	word_t rd_b_q;
	logic  re_a;
	logic  re_b;
	idx_t  addr_a;
	idx_t  addr_b;
	logic  we;
	idx_t  waddr;
	word_t wdata;

	logic  draw_xfer;
	logic  out_free;
	word_t seed_mix;
	word_t seed_next;
	idx_t  far_idx;
	idx_t  next_idx;

	// APB: single register, always ready
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SEED) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_SEED) begin
			seed_q <= pwdata;
		end
	end

	assign draw_ready = (state_q == ST_IDLE);
	assign draw_xfer  = draw_valid && draw_ready;
	assign out_free   = !word_valid_q || word_ready;
	assign word_valid  = word_valid_q;
	assign random_word = random_word_q;

	// seed recurrence: next = M * (p ^ (p >> 30)) + k + 1
	assign seed_mix  = prev_q ^ (prev_q >> 30);
	assign seed_next = word_t'(INIT_MULT * seed_mix) + {22'd0, k_q} + 32'd1;

	// twist read addresses; far entries below WRAP_START are still old words,
	// the rest were rewritten earlier in this pass, as the recurrence requires
	assign far_idx  = (k_q < WRAP_START) ? idx_t'(k_q + FAR_ADD) : idx_t'(k_q - WRAP_START);
	assign next_idx = (k_q == LAST_IDX) ? '0 : idx_t'(k_q + 1'b1);

	// memory port control
	always_comb begin
		re_a   = 1'b0;
		re_b   = 1'b0;
		addr_a = next_idx;
		addr_b = far_idx;
		we     = 1'b0;
		waddr  = k_q;
		wdata  = prev_q;
		case (state_q)
			ST_SEED: begin
				we = 1'b1;
			end
			ST_TW_PRIME: begin
				re_a   = 1'b1;
				addr_a = '0;
			end
			ST_TW_RUN: begin
				re_a = 1'b1;
				re_b = 1'b1;
			end
			ST_RD_ISSUE: begin
				re_a   = 1'b1;
				addr_a = read_idx_q;
			end
			default: begin
			end
		endcase
		// twist write-back lands in the cycle after its reads; its entry is never read
		// in the same cycle, so no forwarding is needed
		if (tw_v_s1) begin
			we    = 1'b1;
			waddr = tw_k_s1;
			wdata = twist_word(cur_q, rd_a_q, rd_b_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rd_a_q <= mem[addr_a];
		end
		if (re_b) begin
			rd_b_q <= mem[addr_b];
		end
	end

	// sequencer, indices and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			read_idx_q   <= WORDS_IDX;
			seeded_q     <= 1'b0;
			k_q          <= '0;
			tw_v_s1      <= 1'b0;
			tw_k_s1      <= '0;
			word_valid_q <= 1'b0;
		end else begin
			// result valid: set when a word is loaded, cleared on its transfer
			if (state_q == ST_RD_DATA && out_free) begin
				word_valid_q <= 1'b1;
			end else if (word_valid_q && word_ready) begin
				word_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (draw_xfer) begin
						k_q <= '0;
						if (reseed || !seeded_q) begin
							state_q <= ST_SEED;
						end else if (read_idx_q >= WORDS_IDX) begin
							state_q <= ST_TW_PRIME;
						end else begin
							state_q <= ST_RD_ISSUE;
						end
					end
				end
				ST_SEED: begin
					// wraps to 0 after the last word, ready for the twist
					k_q <= next_idx;
					if (k_q == LAST_IDX) begin
						seeded_q   <= 1'b1;
						read_idx_q <= WORDS_IDX;
						state_q    <= ST_TW_PRIME;
					end
				end
				ST_TW_PRIME: begin
					state_q <= ST_TW_RUN;
				end
				ST_TW_RUN: begin
					tw_v_s1 <= 1'b1;
					tw_k_s1 <= k_q;
					k_q     <= next_idx;
					if (k_q == LAST_IDX) begin
						state_q <= ST_TW_END;
					end
				end
				ST_TW_END: begin
					tw_v_s1    <= 1'b0;
					read_idx_q <= '0;
					state_q    <= ST_RD_ISSUE;
				end
				ST_RD_ISSUE: begin
					read_idx_q <= idx_t'(read_idx_q + 1'b1);
					state_q    <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers: seed chain, twist current word, result word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && draw_xfer) begin
			prev_q <= seed_q;
		end else if (state_q == ST_SEED) begin
			prev_q <= seed_next;
		end
		if (state_q == ST_TW_RUN) begin
			cur_q <= rd_a_q;
		end
		if (state_q == ST_RD_DATA && out_free) begin
			random_word_q <= temper(rd_a_q);
		end
	end

	`MTG_ASSERT_NOW(a_tw_write_in_twist, tw_v_s1, (state_q == ST_TW_RUN || state_q == ST_TW_END))
	`MTG_ASSERT_NOW(a_read_in_range, (state_q == ST_RD_ISSUE), (seeded_q && read_idx_q < WORDS_IDX))
	`MTG_ASSERT_NEXT(a_reseed_seeds, (draw_xfer && reseed), (state_q == ST_SEED && k_q == '0))

endmodule

// ===== dv/mersenne_twister_generator_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the MT19937 generator: follows APB seed writes and draw transfers,
// predicts each tempered word and compares it with the result channel.
// Depends on mtg_pkg.
module mersenne_twister_generator_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	input  logic [31:0]    prdata,
	input  logic           pready,
	input  logic           draw_valid,
	input  logic           draw_ready,
	input  logic           reseed,
	input  logic           word_valid,
	input  logic           word_ready,
	input  mtg_pkg::word_t random_word,
	output int unsigned    fail_count,
	output int unsigned    words_pending
);
	import mtg_pkg::*;

	localparam logic [2:0] SEED_ADDR = {REG_SEED, 2'b00};
	localparam int unsigned PRINT_CAP = 20;

	// shadow of the generator: seed register, state words, read position, seeded flag
	word_t       seed_reg;
	word_t       mt_state [STATE_WORDS];
	int unsigned mt_pos;
	logic        mt_seeded;
	word_t       words_due [$];

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		if (fail_count < PRINT_CAP)
			$display("%0t ns: %s: got %08h, want %08h", $time, what, got, want);
		fail_count++;
	endtask

	// Next word of the sequence for one draw, with optional reseed first
	function automatic word_t next_mt_word(input logic rs);
		word_t y;
		word_t lo;
		word_t v;
		if (rs || !mt_seeded) begin
			mt_state[0] = seed_reg;
			for (int k = 1; k < STATE_WORDS; k++)
				mt_state[k] = INIT_MULT * (mt_state[k-1] ^ (mt_state[k-1] >> 30)) + word_t'(k);
			mt_pos = STATE_WORDS;
			mt_seeded = 1'b1;
		end
		// in-place twist once the block of words is used up; last word wraps to word 0
		if (mt_pos >= STATE_WORDS) begin
			for (int k = 0; k < STATE_WORDS; k++) begin
				lo = mt_state[(k + 1) % STATE_WORDS];
				y = (mt_state[k] & UPPER_BIT) | (lo & LOWER_BITS);
				v = (y >> 1) ^ (lo[0] ? TWIST_MATRIX : 32'd0);
				mt_state[k] = mt_state[(k + SHIFT_OFFSET) % STATE_WORDS] ^ v;
			end
			mt_pos = 0;
		end
		v = mt_state[mt_pos];
		mt_pos++;
		// tempering
		v ^= v >> 11;
		v ^= (v << 7) & TEMPER_B;
		v ^= (v << 15) & TEMPER_C;
		v ^= v >> 18;
		return v;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			seed_reg = SEED_RESET;
			mt_pos = STATE_WORDS;
			mt_seeded = 1'b0;
			words_due.delete();
			fail_count = 0;
		end else begin
			// APB access phase: writes update the seed, reads must return it
			if (psel && penable && pready && paddr == SEED_ADDR) begin
				if (pwrite)
					seed_reg = pwdata;
				else if (prdata !== seed_reg)
					report_mismatch("seed read-back", prdata, seed_reg);
			end
			// result transfer against the oldest prediction
			if (word_valid && word_ready) begin
				if (words_due.size() == 0)
					report_mismatch("word with no draw pending", random_word, 32'd0);
				else if (random_word !== words_due[0]) begin
					report_mismatch("random_word", random_word, words_due[0]);
					void'(words_due.pop_front());
				end else
					void'(words_due.pop_front());
			end
			// draw transfer
			if (draw_valid && draw_ready)
				words_due.push_back(next_mt_word(reseed));
		end
		words_pending = words_due.size();
	end

endmodule

// ===== dv/mersenne_twister_generator_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for mersenne_twister_generator_top: clock, reset, APB seed setup,
// draw stimulus with random gaps and result back-pressure, watchdog and verdict.
// Depends on mtg_pkg, the generator RTL and mersenne_twister_generator_checker.
module mersenne_twister_generator_top_tb;
	import mtg_pkg::*;

	localparam logic [2:0]  SEED_ADDR   = {REG_SEED, 2'b00};
	localparam logic [2:0]  SPARE_ADDR  = 3'd4;    // register index 1, not mapped
	// worst quiet stretch: a reseed, a full twist, the read pipeline, a stall and a gap
	localparam int unsigned IDLE_LIMIT  = 10000;
	localparam int unsigned PHASE_DRAWS = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        draw_valid;
	logic        draw_ready;
	logic        reseed;
	logic        word_valid;
	logic        word_ready;
	word_t       random_word;

	int unsigned fail_count;
	int unsigned words_pending;
	int unsigned draws_done = 0;
	int unsigned words_done = 0;
	int unsigned idle_cycles = 0;
	int unsigned reseeds_sent = 0;
	int unsigned seeds_set = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;

	always #5 clk = ~clk;

	mersenne_twister_generator_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.draw_valid  (draw_valid),
		.draw_ready  (draw_ready),
		.reseed      (reseed),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.random_word (random_word)
	);

	mersenne_twister_generator_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.draw_valid    (draw_valid),
		.draw_ready    (draw_ready),
		.reseed        (reseed),
		.word_valid    (word_valid),
		.word_ready    (word_ready),
		.random_word   (random_word),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	// transfer counters and watchdog on quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (draw_valid && draw_ready)
				draws_done <= draws_done + 1;
			if (word_valid && word_ready)
				words_done <= words_done + 1;
			if ((draw_valid && draw_ready) || (word_valid && word_ready))
				idle_cycles <= 0;
			else if (idle_cycles == IDLE_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall before each word, with stretches of none
	initial begin
		int unsigned stall;
		word_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				word_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			word_ready <= 1'b1;
			do @(posedge clk); while (!(word_valid && word_ready));
		end
	end

	// one APB transfer: setup then access, then select and enable dropped
	task automatic apb_access(input logic wr, input logic [2:0] addr, input word_t data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_seed(input word_t s);
		apb_access(1'b1, SEED_ADDR, s);
		apb_access(1'b0, SEED_ADDR, 32'd0);
		seeds_set++;
	endtask

	// one draw request after a random gap; valid stays up across back-to-back draws
	task automatic send_draw(input logic rs);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			draw_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		draw_valid <= 1'b1;
		reseed     <= rs;
		do @(posedge clk); while (!draw_ready);
		if (rs)
			reseeds_sent++;
	endtask

	// stop drawing and wait until every word has come back
	task automatic settle();
		draw_valid <= 1'b0;
		do @(posedge clk); while (words_done != draws_done);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		word_t       phase_seed [5];
		int unsigned phase_pct [5];
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= SEED_ADDR;
		pwdata     <= 32'd0;
		draw_valid <= 1'b0;
		reseed     <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first draw seeds from the reset value; a reseed restarts that sequence
		send_draw(1'b0);
		send_draw(1'b0);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b0);
		settle();

		// new seed takes effect only at the next reseed; unmapped register ignored
		set_seed(32'h0000_0000);
		apb_access(1'b1, SPARE_ADDR, $urandom());
		apb_access(1'b0, SEED_ADDR, 32'd0);
		send_draw(1'b0);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b0);
		settle();

		// all-ones seed, reseed on consecutive draws
		set_seed(32'hFFFF_FFFF);
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b1);
		send_draw(1'b0);
		settle();

		set_seed(32'h8000_0000);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b0);

		// random phases: long plain runs cross the twist boundary, later ones reseed often
		phase_seed[0] = $urandom();
		phase_seed[1] = $urandom();
		phase_seed[2] = 32'h0000_0000;
		phase_seed[3] = 32'hFFFF_FFFF;
		phase_seed[4] = $urandom();
		phase_pct[0]  = 0;
		phase_pct[1]  = 0;
		phase_pct[2]  = 3;
		phase_pct[3]  = 15;
		phase_pct[4]  = 40;
		for (int p = 0; p < 5; p++) begin
			settle();
			set_seed(phase_seed[p]);
			for (int n = 0; n < PHASE_DRAWS; n++)
				send_draw($urandom_range(0, 99) < phase_pct[p]);
		end
		settle();
		repeat (20) @(posedge clk);

		$display("Covered %0d draws (%0d reseeding) across %0d seed settings; %0d words seen.",
			draws_done, reseeds_sent, seeds_set, words_done);
		$display("Mismatches: %0d, predictions left unmatched: %0d.", fail_count, words_pending);
		if (fail_count == 0 && words_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== mersenne_twister_generator_top.f =====
+incdir+hw/rtl
hw/rtl/mtg_pkg.sv
hw/rtl/mersenne_twister_generator_top.sv
dv/mersenne_twister_generator_checker.sv
dv/mersenne_twister_generator_top_tb.sv
